>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> rtl/core/impq_pkg.sv
// ----------------------------------------------------------------------------
// impq_pkg
// types and constants of the indexed max priority queue
// ----------------------------------------------------------------------------
`default_nettype none
package impq_pkg;
    localparam int MAX_ITEMS = 256;
    localparam int KEY_BITS  = 32;
    localparam int HANDLE_W  = 8;
    localparam int HANDLES   = 1 << HANDLE_W;
    localparam int POS_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = POS_W + 1;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEL_MAX = 2'd1,
        CMD_CHANGE  = 2'd2,
        CMD_DELETE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_ABSENT  = 3'd3,
        STAT_PRESENT = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_DM_W, S_DL_W, S_CH_W, S_TK, S_TK_H, S_TK_K,
        S_UP_A, S_UP_B, S_UP_C,
        S_DN_A, S_DN_B, S_DN_C, S_DN_D, S_DN_E, S_DN_F,
        S_WR, S_OUT
    } t_state;
endpackage
`default_nettype wire

>>> rtl/core/indexed_max_priority_queue.sv
// ----------------------------------------------------------------------------
// indexed_max_priority_queue
// Indexed binary max-heap over 8-bit handles: insert, delete maximum,
// change key and delete handle, one result beat per command beat.
// A rejected command goes straight to its result beat. An accepted one
// steps through S_UP_A, S_UP_B, S_UP_C per level of upward sift and S_DN_A
// to S_DN_F per level of downward sift (S_DN_D, S_DN_E only with a right
// child); the heap, position and key memories have one read port each and
// allow one lookup per cycle, so each heap level costs a chain of reads.
// The block takes one command at a time and is ready again once the result
// beat has been taken. No clearing pass: presence bits reset at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module indexed_max_priority_queue
    import impq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,  // handle[7:0], key[39:8]
    input  wire logic [1:0]  i_s_axis_tuser,  // command[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata   // removed_handle[7:0], status[10:8],
                                              // count[19:11], is_empty[20]
);
    t_state                r_state, n_state;
    t_status               r_status, n_status;
    logic [HANDLE_W-1:0]   r_h, n_h, r_removed, n_removed;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [HANDLES-1:0]    r_present, n_present;
    logic [POS_W-1:0]      r_p, n_p, r_up, n_up, r_c, n_c;
    logic [HANDLE_W-1:0]   r_hu, n_hu, r_hl, n_hl, r_hr, n_hr, r_node_h, n_node_h;
    logic [KEY_BITS-1:0]   r_kl, n_kl, r_node_k, n_node_k;

    logic [HANDLE_W-1:0]   r_heap_mem [MAX_ITEMS];
    logic [POS_W-1:0]      r_pos_mem  [HANDLES];
    logic [KEY_BITS-1:0]   r_key_mem  [HANDLES];
    logic [HANDLE_W-1:0]   r_heap_q;
    logic [POS_W-1:0]      r_pos_q;
    logic [KEY_BITS-1:0]   r_key_q;

    logic                  heap_we, pos_we, key_we;
    logic [POS_W-1:0]      heap_wa, heap_ra, pos_wd;
    logic [HANDLE_W-1:0]   heap_wd, pos_wa, pos_ra, key_wa, key_ra;
    logic [KEY_BITS-1:0]   key_wd;

    logic                  in_beat;
    t_cmd                  in_cmd;
    logic [HANDLE_W-1:0]   in_h;
    logic [KEY_BITS-1:0]   in_key;
    logic [CNT_W-1:0]      child, last;

    assign in_beat = i_s_axis_tvalid && o_s_axis_tready;
    assign in_cmd  = t_cmd'(i_s_axis_tuser);
    assign in_h    = i_s_axis_tdata[HANDLE_W-1:0];
    assign in_key  = i_s_axis_tdata[HANDLE_W +: KEY_BITS];
    assign child   = {r_p, 1'b1};
    assign last    = r_count - CNT_W'(1);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {3'b000, (r_count == '0), r_count, r_status, r_removed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_present <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_present <= n_present;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_h      <= n_h;
        r_removed <= n_removed;
        r_p      <= n_p;
        r_up     <= n_up;
        r_c      <= n_c;
        r_hu     <= n_hu;
        r_hl     <= n_hl;
        r_hr     <= n_hr;
        r_kl     <= n_kl;
        r_node_h <= n_node_h;
        r_node_k <= n_node_k;
    end

    // memories with one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            r_heap_mem[heap_wa] <= heap_wd;
        end
        r_heap_q <= r_heap_mem[heap_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[pos_wa] <= pos_wd;
        end
        r_pos_q <= r_pos_mem[pos_ra];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[key_wa] <= key_wd;
        end
        r_key_q <= r_key_mem[key_ra];
    end

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_h       = r_h;
        n_removed = r_removed;
        n_count   = r_count;
        n_present = r_present;
        n_p       = r_p;
        n_up      = r_up;
        n_c       = r_c;
        n_hu      = r_hu;
        n_hl      = r_hl;
        n_hr      = r_hr;
        n_kl      = r_kl;
        n_node_h  = r_node_h;
        n_node_k  = r_node_k;
        heap_we   = 1'b0;
        heap_wa   = r_p;
        heap_wd   = r_node_h;
        heap_ra   = '0;
        pos_we    = 1'b0;
        pos_wa    = r_node_h;
        pos_wd    = r_p;
        pos_ra    = in_h;
        key_we    = 1'b0;
        key_wa    = in_h;
        key_wd    = in_key;
        key_ra    = r_heap_q;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_h       = in_h;
                    n_status  = STAT_OK;
                    n_removed = '0;
                    n_node_h  = in_h;
                    n_node_k  = in_key;
                    n_state   = S_OUT;
                    unique case (in_cmd)
                        CMD_INSERT: begin
                            if (r_present[in_h]) begin
                                n_status = STAT_PRESENT;
                            end else if (r_count == CNT_W'(MAX_ITEMS)) begin
                                n_status = STAT_FULL;
                            end else begin
                                key_we           = 1'b1;
                                n_present[in_h]  = 1'b1;
                                n_p              = r_count[POS_W-1:0];
                                n_count          = r_count + CNT_W'(1);
                                n_state          = S_UP_A;
                            end
                        end
                        CMD_DEL_MAX: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                heap_ra = '0;
                                n_state = S_DM_W;
                            end
                        end
                        CMD_CHANGE: begin
                            if (!r_present[in_h]) begin
                                n_status = STAT_ABSENT;
                            end else begin
                                key_we  = 1'b1;
                                n_state = S_CH_W;
                            end
                        end
                        CMD_DELETE: begin
                            if (!r_present[in_h]) begin
                                n_status = STAT_ABSENT;
                            end else begin
                                n_state = S_DL_W;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_DM_W: begin
                n_removed            = r_heap_q;
                n_present[r_heap_q]  = 1'b0;
                n_p                  = '0;
                n_state              = S_TK;
            end
            S_DL_W: begin
                n_removed        = r_h;
                n_present[r_h]   = 1'b0;
                n_p              = r_pos_q;
                n_state          = S_TK;
            end
            S_CH_W: begin
                n_p     = r_pos_q;
                n_state = S_UP_A;
            end
            // the last slot fills the freed one
            S_TK: begin
                n_count = last;
                if ({1'b0, r_p} == last) begin
                    n_state = S_OUT;
                end else begin
                    heap_ra = last[POS_W-1:0];
                    n_state = S_TK_H;
                end
            end
            S_TK_H: begin
                n_node_h = r_heap_q;
                key_ra   = r_heap_q;
                n_state  = S_TK_K;
            end
            S_TK_K: begin
                n_node_k = r_key_q;
                n_state  = S_UP_A;
            end
            S_UP_A: begin
                if (r_p == '0) begin
                    n_state = S_DN_A;
                end else begin
                    n_up    = (r_p - POS_W'(1)) >> 1;
                    heap_ra = (r_p - POS_W'(1)) >> 1;
                    n_state = S_UP_B;
                end
            end
            S_UP_B: begin
                key_ra  = r_heap_q;
                n_hu    = r_heap_q;
                n_state = S_UP_C;
            end
            S_UP_C: begin
                if (r_node_k > r_key_q) begin
                    heap_we = 1'b1;
                    heap_wd = r_hu;
                    pos_we  = 1'b1;
                    pos_wa  = r_hu;
                    n_p     = r_up;
                    n_state = S_UP_A;
                end else begin
                    n_state = S_DN_A;
                end
            end
            S_DN_A: begin
                if (child >= r_count) begin
                    n_state = S_WR;
                end else begin
                    n_c     = child[POS_W-1:0];
                    heap_ra = child[POS_W-1:0];
                    n_state = S_DN_B;
                end
            end
            S_DN_B: begin
                key_ra  = r_heap_q;
                n_hl    = r_heap_q;
                n_state = S_DN_C;
            end
            S_DN_C: begin
                n_kl = r_key_q;
                if (({1'b0, r_c} + CNT_W'(1)) < r_count) begin
                    heap_ra = r_c + POS_W'(1);
                    n_state = S_DN_D;
                end else begin
                    n_state = S_DN_F;
                end
            end
            S_DN_D: begin
                key_ra  = r_heap_q;
                n_hr    = r_heap_q;
                n_state = S_DN_E;
            end
            S_DN_E: begin
                if (r_key_q > r_kl) begin
                    n_hl = r_hr;
                    n_kl = r_key_q;
                    n_c  = r_c + POS_W'(1);
                end
                n_state = S_DN_F;
            end
            S_DN_F: begin
                if (r_node_k >= r_kl) begin
                    n_state = S_WR;
                end else begin
                    heap_we = 1'b1;
                    heap_wd = r_hl;
                    pos_we  = 1'b1;
                    pos_wa  = r_hl;
                    n_p     = r_c;
                    n_state = S_DN_A;
                end
            end
            S_WR: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(MAX_ITEMS))
    `ASSERT_NEVER(a_one_at_a_time, i_clk, i_rst_n, o_s_axis_tready && o_m_axis_tvalid)
    `ASSERT_PROP(a_count_holds, i_clk, i_rst_n, o_s_axis_tready && !i_s_axis_tvalid |=> $stable(r_count))
    `ASSERT_PROP(a_empty_flag, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[20] == (r_count == '0)))
endmodule
`default_nettype wire

>>> bench/tb_indexed_max_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_indexed_max_priority_queue
// Self-checking bench for the indexed max heap: a local heap model predicts
// every result beat; directed cases cover rejects, equal keys, a full queue
// and handle deletes, then random traffic under three handshake idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_indexed_max_priority_queue
    import impq_pkg::*;
();

    typedef struct packed {
        logic       empty;
        logic [8:0] count;
        t_status    status;
        logic [7:0] removed;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;   // handle[7:0], key[39:8]
    logic [1:0]  i_s_axis_tuser;   // command[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;   // removed_handle[7:0], status[10:8],
                                   // count[19:11], is_empty[20]

    indexed_max_priority_queue u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // heap model state
    logic [7:0]  heap_q [MAX_ITEMS];
    logic [8:0]  slot_q [HANDLES];
    logic [31:0] key_q  [HANDLES];
    bit          live_q [HANDLES];
    int          heap_cnt;

    t_result     pending_results [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          errors;
    int          beats_sent;
    int          beats_checked;
    int          cmd_seen [4];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [31:0] slot_key(int s);
        return key_q[heap_q[s]];
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [7:0] ha;
        logic [7:0] hb;
        ha = heap_q[a];
        hb = heap_q[b];
        heap_q[a] = hb;
        heap_q[b] = ha;
        slot_q[ha] = 9'(b);
        slot_q[hb] = 9'(a);
    endfunction

    function automatic void sift_up(int p);
        int up;
        while (p > 0) begin
            up = (p - 1) / 2;
            if (slot_key(p) <= slot_key(up)) break;
            swap_slots(p, up);
            p = up;
        end
    endfunction

    function automatic void sift_down(int p);
        int c;
        forever begin
            c = 2 * p + 1;
            if (c >= heap_cnt) break;
            if (c + 1 < heap_cnt && slot_key(c + 1) > slot_key(c)) c++;
            if (slot_key(p) >= slot_key(c)) break;
            swap_slots(p, c);
            p = c;
        end
    endfunction

    function automatic void remove_slot(int pos);
        live_q[heap_q[pos]] = 0;
        swap_slots(pos, heap_cnt - 1);
        heap_cnt--;
        if (pos < heap_cnt) begin
            sift_up(pos);
            sift_down(slot_q[heap_q[pos]]);
        end
    endfunction

    function automatic t_result queue_update(t_cmd cmd, logic [7:0] h, logic [31:0] key);
        t_result r;
        r = '0;
        r.status = STAT_OK;
        case (cmd)
            CMD_INSERT: begin
                if (live_q[h]) r.status = STAT_PRESENT;
                else if (heap_cnt >= MAX_ITEMS) r.status = STAT_FULL;
                else begin
                    key_q[h] = key;
                    live_q[h] = 1;
                    heap_q[heap_cnt] = h;
                    slot_q[h] = 9'(heap_cnt);
                    heap_cnt++;
                    sift_up(heap_cnt - 1);
                end
            end
            CMD_DEL_MAX: begin
                if (heap_cnt == 0) r.status = STAT_EMPTY;
                else begin
                    r.removed = heap_q[0];
                    remove_slot(0);
                end
            end
            CMD_CHANGE: begin
                if (!live_q[h]) r.status = STAT_ABSENT;
                else begin
                    key_q[h] = key;
                    sift_up(slot_q[h]);
                    sift_down(slot_q[h]);
                end
            end
            default: begin
                if (!live_q[h]) r.status = STAT_ABSENT;
                else begin
                    r.removed = h;
                    remove_slot(slot_q[h]);
                end
            end
        endcase
        r.count = 9'(heap_cnt);
        r.empty = (heap_cnt == 0);
        return r;
    endfunction

    task automatic send_cmd(t_cmd cmd, logic [7:0] h, logic [31:0] key);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {key, h};
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_results.push_back(queue_update(cmd, h, key));
        beats_sent++;
        cmd_seen[cmd]++;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[20:0]);
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: %h", o_m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                beats_checked++;
                if (got.removed !== want.removed) begin
                    $error("removed_handle exp %0d got %0d", want.removed, got.removed);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.count !== want.count) begin
                    $error("count exp %0d got %0d", want.count, got.count);
                    errors++;
                end
                if (got.empty !== want.empty) begin
                    $error("is_empty exp %0d got %0d", want.empty, got.empty);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [7:0] pick_live();
        if (heap_cnt == 0) return 8'($urandom_range(255));
        return heap_q[$urandom_range(heap_cnt - 1)];
    endfunction

    function automatic logic [31:0] rand_key();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return 32'hffff_ffff - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_rejects();
        send_cmd(CMD_DEL_MAX, 8'd0, 32'd0);
        send_cmd(CMD_CHANGE, 8'd255, 32'd5);
        send_cmd(CMD_DELETE, 8'd0, 32'd0);
        send_cmd(CMD_INSERT, 8'd255, 32'hffff_ffff);
        send_cmd(CMD_INSERT, 8'd255, 32'd1);
        send_cmd(CMD_DEL_MAX, 8'd0, 32'd0);
    endtask

    task automatic test_equal_keys();
        for (int i = 0; i < 5; i++) send_cmd(CMD_INSERT, 8'(i), 32'd7);
        send_cmd(CMD_INSERT, 8'd9, 32'd0);
        send_cmd(CMD_CHANGE, 8'd9, 32'd7);
        send_cmd(CMD_CHANGE, 8'd0, 32'd0);
        send_cmd(CMD_CHANGE, 8'd4, 32'hffff_ffff);
        send_cmd(CMD_DELETE, 8'd2, 32'd0);
        send_cmd(CMD_DELETE, 8'd9, 32'd0);
        for (int i = 0; i < 5; i++) send_cmd(CMD_DEL_MAX, 8'd0, 32'd0);
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < HANDLES; i++) send_cmd(CMD_INSERT, 8'(i), rand_key());
        send_cmd(CMD_INSERT, 8'd17, 32'd3);
        for (int i = 0; i < 40; i++) send_cmd(CMD_DELETE, pick_live(), 32'd0);
        send_cmd(CMD_CHANGE, pick_live(), rand_key());
        for (int i = 0; i < 30; i++) send_cmd(CMD_DEL_MAX, 8'd0, 32'd0);
    endtask

    task automatic test_random(int n);
        int c;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(99);
            if (i == n / 2) wait_drained();
            if (c < 40 - (heap_cnt > 40 ? 15 : 0))
                send_cmd(CMD_INSERT, 8'($urandom_range(255)), rand_key());
            else if (c < 60) send_cmd(CMD_DEL_MAX, 8'($urandom), rand_key());
            else if (c < 80)
                send_cmd(CMD_CHANGE, c < 77 ? pick_live() : 8'($urandom), rand_key());
            else send_cmd(CMD_DELETE, c < 97 ? pick_live() : 8'($urandom), $urandom);
        end
    endtask

    initial begin
        int guard;
        errors = 0;
        heap_cnt = 0;
        beats_sent = 0;
        beats_checked = 0;
        for (int i = 0; i < HANDLES; i++) live_q[i] = 0;
        send_idle_pct = 33;
        recv_idle_pct = 67;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_rejects();
        test_equal_keys();
        test_random(70);
        send_idle_pct = 67;
        recv_idle_pct = 33;
        test_full_queue();
        test_random(65);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(65);

        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (100) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("sent %0d commands (insert %0d, del-max %0d, change %0d, delete %0d)",
                 beats_sent, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
        $display("checked %0d result beats including a full queue and three idle mixes",
                 beats_checked);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
